>>> rtl/fmcc_pkg.sv
// ----------------------------------------------------------------------------
// fmcc_pkg
// Shared widths, command and duty action codes, and types of the four-motor
// command controller.
// ----------------------------------------------------------------------------
package fmcc_pkg;

  // motor count and field widths
  localparam int MOTOR_COUNT = 4;
  localparam int OP_W        = 3;
  localparam int MOT_W       = 2;
  localparam int SPD_W       = 8;
  localparam int DUTY_W      = 16;
  localparam int MASK_W      = 4;

  // compare arithmetic widths: top+1 = 100*int + frac
  localparam int INT_W   = 10;
  localparam int FRAC_W  = 7;
  localparam int INV_W   = 7;
  localparam int HI_W    = DUTY_W + 1;
  localparam int LO_W    = 14;
  localparam int RECIP_W = 13;
  localparam int CFG_N_W = DUTY_W + 1;

  // command codes
  localparam logic [OP_W-1:0] OP_START  = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd1;
  localparam logic [OP_W-1:0] OP_SPEED  = 3'd2;
  localparam logic [OP_W-1:0] OP_SETDIR = 3'd3;
  localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;
  localparam logic [OP_W-1:0] OP_ESTOP  = 3'd5;
  localparam logic [OP_W-1:0] OP_UNLOCK = 3'd6;

  // per-motor compare update actions
  localparam int DACT_W = 3;
  localparam logic [DACT_W-1:0] DUTY_KEEP  = 3'd0;
  localparam logic [DACT_W-1:0] DUTY_ZERO  = 3'd1;
  localparam logic [DACT_W-1:0] DUTY_TOP   = 3'd2;
  localparam logic [DACT_W-1:0] DUTY_SPD   = 3'd3;
  localparam logic [DACT_W-1:0] DUTY_START = 3'd4;

  // constants
  localparam logic [SPD_W-1:0]  START_SPEED    = 8'd70;
  localparam logic [INV_W-1:0]  START_INV      = 7'd30;
  localparam logic [INV_W-1:0]  FULL_PCT       = 7'd100;
  localparam logic [DUTY_W-1:0] TOP_RESET      = 16'd49;
  localparam logic [INT_W-1:0]  TOP_INT_RESET  = 10'd0;
  localparam logic [FRAC_W-1:0] TOP_FRAC_RESET = 7'd50;

  // reciprocals of 100: exact for n < 43690 and n < 91180
  localparam logic [RECIP_W-1:0] RECIP_LO    = 13'd5243;
  localparam int                 RECIP_LO_SH = 19;
  localparam logic [CFG_N_W-1:0] RECIP_CFG   = 17'd83887;
  localparam int                 RECIP_CFG_SH = 23;

  // one accepted command
  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [MOT_W-1:0] motor;
    logic             all_motors;
    logic [SPD_W-1:0] speed;
    logic             direction;
  } cmd_t;

  // compare update request from the command stage to the duty stage
  typedef struct packed {
    logic [MOTOR_COUNT-1:0][DACT_W-1:0] act;
    logic [HI_W-1:0]                    spd_hi;
    logic [LO_W-1:0]                    spd_lo;
    logic [HI_W-1:0]                    st_hi;
    logic [LO_W-1:0]                    st_lo;
  } duty_req_t;

endpackage

>>> rtl/fmcc_if.sv
// ----------------------------------------------------------------------------
// fmcc_if
// Valid/ready channels of the four-motor command controller: command,
// result and configuration write.
// ----------------------------------------------------------------------------

// command channel
interface fmcc_cmd_if import fmcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [MOT_W-1:0] motor;
  logic             all_motors;
  logic [SPD_W-1:0] speed;
  logic             direction;

  modport source (output valid, opcode, motor, all_motors, speed, direction,
                  input ready);
  modport sink (input valid, opcode, motor, all_motors, speed, direction,
                output ready);
endinterface

// result channel
interface fmcc_res_if import fmcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_a;
  logic [DUTY_W-1:0] duty_b;
  logic [DUTY_W-1:0] duty_c;
  logic [DUTY_W-1:0] duty_d;
  logic [MASK_W-1:0] drive_enable_mask;
  logic [MASK_W-1:0] reverse_pin_mask;
  logic [MASK_W-1:0] running_mask;
  logic              locked;

  modport source (output valid, duty_a, duty_b, duty_c, duty_d, drive_enable_mask,
                  reverse_pin_mask, running_mask, locked, input ready);
  modport sink (input valid, duty_a, duty_b, duty_c, duty_d, drive_enable_mask,
                reverse_pin_mask, running_mask, locked, output ready);
endinterface

// configuration write channel
interface fmcc_cfg_if import fmcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/four_motor_command_controller.sv
// ----------------------------------------------------------------------------
// four_motor_command_controller
// Four-motor command decoder with lock, per-motor speed, direction, pin state
// and PWM compare values.
// ----------------------------------------------------------------------------
// path: command beat to result valid through the command register, the
//   partial product register, and the compare and result register
// throughput: one command per cycle; a stalled result beat holds the whole pipe
// reset: synchronous, all motors stopped, compares and period top 49, unlocked
// configuration write takes effect at once, cfg ready is always high
module four_motor_command_controller import fmcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fmcc_cmd_if.sink    in_cmd,
  fmcc_res_if.source  out_res,
  fmcc_cfg_if.sink    cfg_wr
);

  // pipe control
  logic adv;
  logic v1_r;
  logic v2_r;
  logic out_valid_r;

  // stage 1 command register
  cmd_t cmd_r;

  // configuration: top and its split top+1 = 100*int + frac
  logic [DUTY_W-1:0]           top_r;
  logic [INT_W-1:0]            top_int_r;
  logic [FRAC_W-1:0]           top_frac_r;
  logic [CFG_N_W-1:0]          cfg_n;
  logic [2*CFG_N_W-1:0]        cfg_prod;
  logic [INT_W-1:0]            cfg_int;
  logic [CFG_N_W-1:0]          cfg_rem;

  // motor state
  logic [MOTOR_COUNT-1:0][SPD_W-1:0] spd_r;
  logic [MOTOR_COUNT-1:0][SPD_W-1:0] spd_nxt;
  logic [MOTOR_COUNT-1:0]            run_r;
  logic [MOTOR_COUNT-1:0]            run_nxt;
  logic [MOTOR_COUNT-1:0]            dir_r;
  logic [MOTOR_COUNT-1:0]            dir_nxt;
  logic [MOTOR_COUNT-1:0]            en_r;
  logic [MOTOR_COUNT-1:0]            en_nxt;
  logic [MOTOR_COUNT-1:0]            rev_r;
  logic [MOTOR_COUNT-1:0]            rev_nxt;
  logic                              lock_r;
  logic                              lock_nxt;

  // stage 2 registers
  duty_req_t                req_nxt;
  duty_req_t                req_r;
  logic [MOTOR_COUNT-1:0]   s2_en_r;
  logic [MOTOR_COUNT-1:0]   s2_rev_r;
  logic [MOTOR_COUNT-1:0]   s2_run_r;
  logic                     s2_lock_r;

  // result registers
  logic [MOTOR_COUNT-1:0]   o_en_r;
  logic [MOTOR_COUNT-1:0]   o_rev_r;
  logic [MOTOR_COUNT-1:0]   o_run_r;
  logic                     o_lock_r;

  logic [MOTOR_COUNT-1:0][DUTY_W-1:0] duty;
  logic [INV_W-1:0]                   inv;

  // whole pipe moves unless a result beat is stalled
  assign adv          = !out_valid_r || out_res.ready;
  assign in_cmd.ready = adv;
  assign cfg_wr.ready = 1'b1;

  // split of the written top: int = (top+1)/100 by reciprocal
  assign cfg_n    = {1'b0, cfg_wr.data} + CFG_N_W'(1);
  assign cfg_prod = (2*CFG_N_W)'(cfg_n) * (2*CFG_N_W)'(RECIP_CFG);
  assign cfg_int  = cfg_prod[RECIP_CFG_SH +: INT_W];
  assign cfg_rem  = cfg_n - CFG_N_W'(CFG_N_W'(cfg_int) * CFG_N_W'(FULL_PCT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r      <= TOP_RESET;
      top_int_r  <= TOP_INT_RESET;
      top_frac_r <= TOP_FRAC_RESET;
    end else if (cfg_wr.valid) begin
      top_r      <= cfg_wr.data;
      top_int_r  <= cfg_int;
      top_frac_r <= cfg_rem[FRAC_W-1:0];
    end
  end

  // inverse percent of the requested speed, clamped at 100
  assign inv = (cmd_r.speed > SPD_W'(FULL_PCT)) ? '0
             : FULL_PCT - cmd_r.speed[INV_W-1:0];

  // command decode and motor state update
  always_comb begin
    logic hit_one;
    logic hit_any;
    logic new_dir;
    spd_nxt  = spd_r;
    run_nxt  = run_r;
    dir_nxt  = dir_r;
    en_nxt   = en_r;
    rev_nxt  = rev_r;
    lock_nxt = lock_r;
    new_dir  = 1'b0;
    req_nxt.spd_hi = HI_W'(inv) * HI_W'(top_int_r);
    req_nxt.spd_lo = LO_W'(inv) * LO_W'(top_frac_r);
    req_nxt.st_hi  = HI_W'(START_INV) * HI_W'(top_int_r);
    req_nxt.st_lo  = LO_W'(START_INV) * LO_W'(top_frac_r);
    if (cmd_r.opcode == OP_ESTOP) begin
      lock_nxt = 1'b1;
    end else if (cmd_r.opcode == OP_UNLOCK) begin
      lock_nxt = 1'b0;
    end
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      req_nxt.act[m] = DUTY_KEEP;
      hit_one = (cmd_r.motor == MOT_W'(m));
      hit_any = hit_one || cmd_r.all_motors;
      unique case (cmd_r.opcode) inside
        OP_ESTOP: begin
          spd_nxt[m]     = '0;
          run_nxt[m]     = 1'b0;
          en_nxt[m]      = 1'b0;
          req_nxt.act[m] = DUTY_ZERO;
        end
        OP_UNLOCK: begin
          spd_nxt[m]     = '0;
          run_nxt[m]     = 1'b0;
          en_nxt[m]      = 1'b0;
          req_nxt.act[m] = DUTY_TOP;
        end
        OP_START: begin
          if (!lock_r && hit_any) begin
            run_nxt[m] = 1'b1;
            en_nxt[m]  = 1'b1;
            rev_nxt[m] = !dir_r[m];
            if (spd_r[m] == '0) begin
              spd_nxt[m]     = START_SPEED;
              req_nxt.act[m] = DUTY_START;
            end
          end
        end
        OP_STOP: begin
          if (!lock_r && hit_any) begin
            spd_nxt[m]     = '0;
            run_nxt[m]     = 1'b0;
            en_nxt[m]      = 1'b0;
            req_nxt.act[m] = DUTY_TOP;
          end
        end
        OP_SPEED: begin
          if (!lock_r && hit_any) begin
            spd_nxt[m]     = cmd_r.speed;
            run_nxt[m]     = (cmd_r.speed != '0);
            en_nxt[m]      = (cmd_r.speed != '0);
            req_nxt.act[m] = DUTY_SPD;
            if (cmd_r.speed != '0) begin
              rev_nxt[m] = !dir_r[m];
            end
          end
        end
        OP_SETDIR, OP_REVERSE: begin
          if (!lock_r && hit_one) begin
            new_dir    = (cmd_r.opcode == OP_SETDIR) ? cmd_r.direction : !dir_r[m];
            dir_nxt[m] = new_dir;
            // pins follow only for a running motor
            if (run_r[m]) begin
              en_nxt[m] = (spd_r[m] != '0);
              if (spd_r[m] != '0) begin
                rev_nxt[m] = !new_dir;
              end
            end
          end
        end
        default: begin
          req_nxt.act[m] = DUTY_KEEP;
        end
      endcase
    end
  end

  // pipe valids and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      spd_r       <= '0;
      run_r       <= '0;
      dir_r       <= '0;
      en_r        <= '0;
      rev_r       <= '0;
      lock_r      <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_cmd.valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
      if (v1_r) begin
        spd_r  <= spd_nxt;
        run_r  <= run_nxt;
        dir_r  <= dir_nxt;
        en_r   <= en_nxt;
        rev_r  <= rev_nxt;
        lock_r <= lock_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r.opcode     <= in_cmd.opcode;
      cmd_r.motor      <= in_cmd.motor;
      cmd_r.all_motors <= in_cmd.all_motors;
      cmd_r.speed      <= in_cmd.speed;
      cmd_r.direction  <= in_cmd.direction;
      req_r            <= req_nxt;
      s2_en_r          <= en_nxt;
      s2_rev_r         <= rev_nxt;
      s2_run_r         <= run_nxt;
      s2_lock_r        <= lock_nxt;
      o_en_r           <= s2_en_r;
      o_rev_r          <= s2_rev_r;
      o_run_r          <= s2_run_r;
      o_lock_r         <= s2_lock_r;
    end
  end

  // compare finish and store
  fmcc_duty u_duty (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (adv && v2_r),
    .req    (req_r),
    .top    (top_r),
    .duty   (duty)
  );

  // result beat
  assign out_res.valid             = out_valid_r;
  assign out_res.duty_a            = duty[0];
  assign out_res.duty_b            = duty[1];
  assign out_res.duty_c            = duty[2];
  assign out_res.duty_d            = duty[3];
  assign out_res.drive_enable_mask = MASK_W'(o_en_r);
  assign out_res.reverse_pin_mask  = MASK_W'(o_rev_r);
  assign out_res.running_mask      = MASK_W'(o_run_r);
  assign out_res.locked            = o_lock_r;

  // emergency stop always leaves the lock set
  a_estop_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v1_r && cmd_r.opcode == OP_ESTOP) |=> lock_r)
    else $error("lock not set after emergency stop");

  // no motor is powered while locked
  a_locked_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    lock_r |-> (en_r == '0))
    else $error("motor powered while locked");

  // a powered motor is always marked running
  a_en_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((en_r & ~run_r) == '0))
    else $error("motor powered but not running");

  // state only moves with a command in stage 1
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && v1_r) |=> ($stable(run_r) && $stable(spd_r) && $stable(lock_r)))
    else $error("motor state changed without a command");

endmodule

>>> rtl/fmcc_duty.sv
// ----------------------------------------------------------------------------
// fmcc_duty
// Compare value store: finishes the divide by 100 of the partial products
// and applies the per-motor compare update of one command.
// ----------------------------------------------------------------------------
module fmcc_duty import fmcc_pkg::*; (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               upd_en,
  input  duty_req_t                          req,
  input  logic [DUTY_W-1:0]                  top,
  output logic [MOTOR_COUNT-1:0][DUTY_W-1:0] duty
);

  logic [MOTOR_COUNT-1:0][DUTY_W-1:0] duty_r;
  logic [MOTOR_COUNT-1:0][DUTY_W-1:0] duty_nxt;
  logic [DUTY_W-1:0]                  spd_cmp;
  logic [DUTY_W-1:0]                  st_cmp;

  // q = hi + lo/100, then q-1 floored at 0 and limited to top
  function automatic logic [DUTY_W-1:0] finish_cmp(input logic [HI_W-1:0]   hi,
                                                   input logic [LO_W-1:0]   lo,
                                                   input logic [DUTY_W-1:0] lim);
    logic [LO_W+RECIP_W-1:0] prod;
    logic [HI_W-1:0]         q;
    logic [HI_W-1:0]         qm1;
    prod = (LO_W+RECIP_W)'(lo) * (LO_W+RECIP_W)'(RECIP_LO);
    q    = hi + HI_W'(prod >> RECIP_LO_SH);
    qm1  = (q == '0) ? '0 : q - HI_W'(1);
    if (qm1 > {1'b0, lim}) begin
      finish_cmp = lim;
    end else begin
      finish_cmp = qm1[DUTY_W-1:0];
    end
  endfunction

  assign spd_cmp = finish_cmp(req.spd_hi, req.spd_lo, top);
  assign st_cmp  = finish_cmp(req.st_hi, req.st_lo, top);

  // per-motor update select
  always_comb begin
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      unique case (req.act[m])
        DUTY_KEEP:  duty_nxt[m] = duty_r[m];
        DUTY_ZERO:  duty_nxt[m] = '0;
        DUTY_TOP:   duty_nxt[m] = top;
        DUTY_SPD:   duty_nxt[m] = spd_cmp;
        DUTY_START: duty_nxt[m] = st_cmp;
        default:    duty_nxt[m] = duty_r[m];
      endcase
    end
  end

  // compare store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        duty_r[m] <= TOP_RESET;
      end
    end else if (upd_en) begin
      duty_r <= duty_nxt;
    end
  end

  assign duty = duty_r;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-motor command controller. Commands are
// driven from a queue at the falling edge, each accepted beat updates a
// motor-state predictor, and every result beat is compared field by field
// with the oldest predicted status. The period top is rewritten between
// phases, and both sides idle in random bursts and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import fmcc_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 100;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 215;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // status word reported after each command
  typedef struct packed {
    logic [MOTOR_COUNT-1:0][DUTY_W-1:0] duty;
    logic [MASK_W-1:0]                  enable;
    logic [MASK_W-1:0]                  reverse;
    logic [MASK_W-1:0]                  running;
    logic                               locked;
  } motor_status_t;

  logic clk;
  logic rst_n;

  fmcc_cmd_if cmd_if ();
  fmcc_res_if res_if ();
  fmcc_cfg_if cfg_if ();

  four_motor_command_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_if),
    .out_res (res_if),
    .cfg_wr  (cfg_if)
  );

  // stimulus and scoreboard storage
  cmd_t          pending_cmds[$];
  motor_status_t expected_status[$];
  motor_status_t want;
  cmd_t          next_cmd;

  int  errors;
  int  idle_cycles;
  bit  progress;
  bit  cmd_taken;
  bit  cfg_taken;
  bit  idle_on;
  bit  hold_go;
  bit  hold_done;
  int  gap_left;
  int  stall_left;
  int  hold_left;

  // predicted motor state
  int unsigned      top_q;
  logic [SPD_W-1:0] speed_q [MOTOR_COUNT];
  logic [DUTY_W-1:0] duty_q [MOTOR_COUNT];
  logic             run_q   [MOTOR_COUNT];
  logic             dir_q   [MOTOR_COUNT];
  logic             en_q    [MOTOR_COUNT];
  logic             rev_q   [MOTOR_COUNT];
  logic             lock_q;

  // clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // compare value for a speed percent at the current top
  function automatic logic [DUTY_W-1:0] compare_value(input logic [SPD_W-1:0] s);
    int unsigned pct;
    int unsigned q;
    pct = (s > 8'd100) ? 100 : 32'(s);
    q = ((100 - pct) * (top_q + 1)) / 100;
    q = (q > 0) ? q - 1 : 0;
    if (q > top_q) q = top_q;
    return q[DUTY_W-1:0];
  endfunction

  function automatic void refresh_pins(input int m);
    if (!run_q[m] || speed_q[m] == '0) begin
      en_q[m] = 1'b0;
    end else begin
      en_q[m]  = 1'b1;
      rev_q[m] = ~dir_q[m];
    end
  endfunction

  function automatic void apply_speed(input int m, input logic [SPD_W-1:0] s);
    speed_q[m] = s;
    duty_q[m]  = compare_value(s);
    run_q[m]   = (s != '0);
    refresh_pins(m);
  endfunction

  function automatic void start_motor(input int m);
    if (speed_q[m] == '0) begin
      apply_speed(m, START_SPEED);
    end else begin
      run_q[m] = 1'b1;
      refresh_pins(m);
    end
  endfunction

  function automatic void stop_motor(input int m);
    run_q[m]   = 1'b0;
    speed_q[m] = '0;
    duty_q[m]  = compare_value('0);
    refresh_pins(m);
  endfunction

  function automatic void reset_model();
    top_q  = 32'(TOP_RESET);
    lock_q = 1'b0;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      speed_q[m] = '0;
      duty_q[m]  = TOP_RESET;
      run_q[m]   = 1'b0;
      dir_q[m]   = 1'b0;
      en_q[m]    = 1'b0;
      rev_q[m]   = 1'b0;
    end
  endfunction

  // state update for one accepted command
  function automatic void execute_command(input cmd_t c);
    int m;
    m = int'(c.motor);
    if (c.opcode == OP_ESTOP) begin
      lock_q = 1'b1;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        duty_q[i]  = '0;
        en_q[i]    = 1'b0;
        run_q[i]   = 1'b0;
        speed_q[i] = '0;
      end
    end else if (c.opcode == OP_UNLOCK) begin
      lock_q = 1'b0;
      for (int i = 0; i < MOTOR_COUNT; i++) stop_motor(i);
    end else if (!lock_q && c.opcode <= OP_REVERSE) begin
      if (c.opcode <= OP_SPEED && c.all_motors) begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          case (c.opcode)
            OP_START: start_motor(i);
            OP_STOP:  stop_motor(i);
            default:  apply_speed(i, c.speed);
          endcase
        end
      end else begin
        case (c.opcode)
          OP_START:  start_motor(m);
          OP_STOP:   stop_motor(m);
          OP_SPEED:  apply_speed(m, c.speed);
          OP_SETDIR: begin
            dir_q[m] = c.direction;
            if (run_q[m]) refresh_pins(m);
          end
          default: begin
            dir_q[m] = ~dir_q[m];
            if (run_q[m]) refresh_pins(m);
          end
        endcase
      end
    end
  endfunction

  function automatic motor_status_t snapshot();
    motor_status_t s;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      s.duty[i]    = duty_q[i];
      s.enable[i]  = en_q[i];
      s.reverse[i] = rev_q[i];
      s.running[i] = run_q[i];
    end
    s.locked = lock_q;
    return s;
  endfunction

  function automatic cmd_t make_cmd(input logic [OP_W-1:0] op, input logic [MOT_W-1:0] mot,
                                    input logic all, input logic [SPD_W-1:0] spd,
                                    input logic dir);
    cmd_t c;
    c.opcode     = op;
    c.motor      = mot;
    c.all_motors = all;
    c.speed      = spd;
    c.direction  = dir;
    return c;
  endfunction

  // mostly unlocked traffic, rare emergency stops, biased speeds
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 18)      c.opcode = OP_START;
    else if (r < 32) c.opcode = OP_STOP;
    else if (r < 60) c.opcode = OP_SPEED;
    else if (r < 74) c.opcode = OP_SETDIR;
    else if (r < 89) c.opcode = OP_REVERSE;
    else if (r < 92) c.opcode = OP_ESTOP;
    else if (r < 98) c.opcode = OP_UNLOCK;
    else             c.opcode = OP_UNUSED;
    c.motor      = MOT_W'($urandom_range(0, MOTOR_COUNT - 1));
    c.all_motors = ($urandom_range(0, 3) == 0);
    c.direction  = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 10)      c.speed = 8'd0;
    else if (r < 20) c.speed = 8'd100;
    else if (r < 25) c.speed = 8'd101;
    else if (r < 30) c.speed = 8'd255;
    else if (r < 35) c.speed = 8'd1;
    else if (r < 40) c.speed = 8'd99;
    else if (r < 85) c.speed = SPD_W'($urandom_range(0, 100));
    else             c.speed = SPD_W'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp_v));
  endtask

  // wait until every command has produced its result, then let the pipe settle
  task automatic drain();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_status.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // command driver: next beat at the falling edge, random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_if.valid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        cmd_if.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 17) - 1;
        cmd_if.valid <= 1'b0;
      end else begin
        next_cmd = pending_cmds.pop_front();
        cmd_if.valid      <= 1'b1;
        cmd_if.opcode     <= next_cmd.opcode;
        cmd_if.motor      <= next_cmd.motor;
        cmd_if.all_motors <= next_cmd.all_motors;
        cmd_if.speed      <= next_cmd.speed;
        cmd_if.direction  <= next_cmd.direction;
      end
    end
  end

  // result ready: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else if (idle_on && stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // monitor: check result beats, predict on command beats
  always @(posedge clk) begin
    cmd_taken <= cmd_if.valid && cmd_if.ready;
    cfg_taken <= cfg_if.valid && cfg_if.ready;
    if (rst_n) begin
      progress = 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        top_q    = 32'(cfg_if.data);
        progress = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        progress = 1'b1;
        if (expected_status.size() == 0) begin
          report_mismatch("result beat with no command outstanding");
        end else begin
          want = expected_status.pop_front();
          check_field("duty_a", 32'(res_if.duty_a), 32'(want.duty[0]));
          check_field("duty_b", 32'(res_if.duty_b), 32'(want.duty[1]));
          check_field("duty_c", 32'(res_if.duty_c), 32'(want.duty[2]));
          check_field("duty_d", 32'(res_if.duty_d), 32'(want.duty[3]));
          check_field("drive_enable_mask", 32'(res_if.drive_enable_mask),
                      32'(want.enable));
          check_field("reverse_pin_mask", 32'(res_if.reverse_pin_mask),
                      32'(want.reverse));
          check_field("running_mask", 32'(res_if.running_mask), 32'(want.running));
          check_field("locked", 32'(res_if.locked), 32'(want.locked));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        progress = 1'b1;
        execute_command(make_cmd(cmd_if.opcode, cmd_if.motor, cmd_if.all_motors,
                                 cmd_if.speed, cmd_if.direction));
        expected_status.push_back(snapshot());
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on cycles without any beat
  initial begin
    do @(negedge clk);
    while (idle_cycles < WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // reset, directed commands, then random phases at several period tops
  initial begin
    rst_n             = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.opcode     = OP_START;
    cmd_if.motor      = '0;
    cmd_if.all_motors = 1'b0;
    cmd_if.speed      = '0;
    cmd_if.direction  = 1'b0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    errors            = 0;
    idle_cycles       = 0;
    cmd_taken         = 1'b0;
    cfg_taken         = 1'b0;
    idle_on           = 1'b1;
    hold_go           = 1'b0;
    hold_done         = 1'b0;
    gap_left          = 0;
    stall_left        = 0;
    hold_left         = 0;
    reset_model();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // start from zero speed, speed extremes, pins on running and stopped motors
    pending_cmds.push_back(make_cmd(OP_START,   2'd0, 1'b0, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_SPEED,   2'd1, 1'b0, 8'd255, 1'b0));
    pending_cmds.push_back(make_cmd(OP_SPEED,   2'd2, 1'b0, 8'd100, 1'b0));
    pending_cmds.push_back(make_cmd(OP_SPEED,   2'd3, 1'b0, 8'd101, 1'b1));
    pending_cmds.push_back(make_cmd(OP_SPEED,   2'd0, 1'b0, 8'd1,   1'b0));
    pending_cmds.push_back(make_cmd(OP_SETDIR,  2'd0, 1'b0, 8'd0,   1'b1));
    pending_cmds.push_back(make_cmd(OP_REVERSE, 2'd1, 1'b1, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_STOP,    2'd2, 1'b0, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_REVERSE, 2'd2, 1'b0, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_SETDIR,  2'd2, 1'b1, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_START,   2'd2, 1'b0, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_START,   2'd1, 1'b0, 8'd0,   1'b0));
    // all-motor forms
    pending_cmds.push_back(make_cmd(OP_SPEED,   2'd0, 1'b1, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_START,   2'd0, 1'b1, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_SPEED,   2'd3, 1'b1, 8'd50,  1'b1));
    pending_cmds.push_back(make_cmd(OP_STOP,    2'd1, 1'b1, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_SPEED,   2'd3, 1'b0, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_START,   2'd3, 1'b0, 8'd0,   1'b0));
    // emergency stop, ignored commands while locked, unused opcode, unlock
    pending_cmds.push_back(make_cmd(OP_ESTOP,   2'd3, 1'b1, 8'd255, 1'b1));
    pending_cmds.push_back(make_cmd(OP_START,   2'd0, 1'b0, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_SPEED,   2'd0, 1'b1, 8'd90,  1'b0));
    pending_cmds.push_back(make_cmd(OP_SETDIR,  2'd1, 1'b0, 8'd0,   1'b1));
    pending_cmds.push_back(make_cmd(OP_UNUSED,  2'd3, 1'b1, 8'd255, 1'b1));
    pending_cmds.push_back(make_cmd(OP_ESTOP,   2'd0, 1'b0, 8'd0,   1'b0));
    pending_cmds.push_back(make_cmd(OP_UNLOCK,  2'd2, 1'b1, 8'd255, 1'b1));
    pending_cmds.push_back(make_cmd(OP_UNUSED,  2'd0, 1'b0, 8'd0,   1'b0));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      // new period top while idle
      @(negedge clk);
      case (p)
        0:       cfg_if.data <= 16'd1;
        1:       cfg_if.data <= 16'hFFFF;
        2:       cfg_if.data <= 16'd100;
        3:       cfg_if.data <= 16'd99;
        4:       cfg_if.data <= DUTY_W'($urandom_range(1, 65535));
        5:       cfg_if.data <= DUTY_W'($urandom_range(1, 300));
        6:       cfg_if.data <= 16'hFFFE;
        default: cfg_if.data <= TOP_RESET;
      endcase
      cfg_if.valid <= 1'b1;
      do @(negedge clk);
      while (!cfg_taken);
      cfg_if.valid <= 1'b0;
      repeat (2) @(negedge clk);
      // no idling in one middle phase and in the last one
      idle_on = (p != 3) && (p != PHASES - 1);
      if (p == 2) hold_go = 1'b1;
      repeat (PHASE_ITEMS) pending_cmds.push_back(random_cmd());
    end
    drain();

    if (expected_status.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_status.size()));
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
